/* rtl/core/rast_pkg.sv */
// Shared constants, types and controller encodings for the range add / range sum core.
package rast_pkg;

	// Array and word sizes.
	localparam int NPOS   = 1024;
	localparam int POS_W  = 10;
	localparam int ADDR_W = 10;
	localparam int IDX_W  = 12;
	localparam int LEN_W  = 11;
	localparam int VAL_W  = 32;
	localparam int SUM_W  = 64;
	localparam int PROD_W = VAL_W + LEN_W + 1;

	// Operation codes.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [SUM_W-1:0]  sum_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_RD,
		ST_MOD,
		ST_MUL,
		ST_ACC,
		ST_NEXT,
		ST_PUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic load;
		logic rd;
		logic modify;
		logic mul;
		logic acc;
		logic put;
		logic clr;
		logic phase;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_fire;
		logic cfg_fire;
		logic op_query;
		logic empty;
		logic walk_done;
		logic clr_last;
		logic out_free;
	} status_t;

endpackage

/* rtl/core/rast_if.sv */
// Handshake channel interfaces for requests, results and the length register.
interface rast_req_if;
	logic                  valid;
	logic                  ready;
	logic                  op;
	rast_pkg::pos_t        range_low;
	rast_pkg::pos_t        range_high;
	logic signed [31:0]    add_value;
	modport source (output valid, op, range_low, range_high, add_value, input ready);
	modport sink   (input valid, op, range_low, range_high, add_value, output ready);
endinterface

interface rast_rsp_if;
	logic                  valid;
	logic                  ready;
	logic signed [63:0]    range_sum;
	modport source (output valid, range_sum, input ready);
	modport sink   (input valid, range_sum, output ready);
endinterface

interface rast_cfg_if;
	logic                  valid;
	logic                  ready;
	rast_pkg::len_t        length_in_use;
	modport source (output valid, length_in_use, input ready);
	modport sink   (input valid, length_in_use, output ready);
endinterface

/* rtl/core/rast_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rast_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/rast_ctrl.sv */
// Controller state machine that sequences clearing, tree walks and result delivery.
module rast_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  rast_pkg::status_t sts,
	output rast_pkg::cmd_t    cmd
);
	import rast_pkg::*;

	state_t state_q, state_d;
	logic   phase_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (sts.in_fire) state_d = ST_LOAD;
			ST_LOAD: begin
				if (sts.empty) state_d = sts.op_query ? ST_PUT : ST_IDLE;
				else state_d = ST_RD;
			end
			ST_RD: begin
				if (sts.walk_done) state_d = sts.op_query ? ST_MUL : ST_NEXT;
				else state_d = ST_MOD;
			end
			ST_MOD:   state_d = ST_RD;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = ST_NEXT;
			ST_NEXT: begin
				if (!phase_q) state_d = ST_LOAD;
				else state_d = sts.op_query ? ST_PUT : ST_IDLE;
			end
			ST_PUT:   if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
		// A length write restarts the clearing sweep.
		if (sts.cfg_fire) state_d = ST_CLEAR;
	end

	// Outputs.
	always_comb begin
		cmd          = '0;
		cmd.phase    = phase_q;
		cmd.in_ready = (state_q == ST_IDLE);
		cmd.load     = (state_q == ST_LOAD);
		cmd.rd       = (state_q == ST_RD) && !sts.walk_done;
		cmd.modify   = (state_q == ST_MOD);
		cmd.mul      = (state_q == ST_MUL);
		cmd.acc      = (state_q == ST_ACC);
		cmd.put      = (state_q == ST_PUT) && sts.out_free;
		cmd.clr      = (state_q == ST_CLEAR);
	end

	// State and walk phase registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) phase_q <= 1'b0;
			else if (state_q == ST_NEXT) phase_q <= 1'b1;
		end
	end

endmodule

/* rtl/core/rast_dp.sv */
// Datapath: two Fenwick tree stores, walk index, multiplier, accumulators and result register.
module rast_dp (
	input  logic              clk,
	input  logic              arst_n,
	rast_req_if.sink          req,
	rast_rsp_if.source        rsp,
	rast_cfg_if.sink          cfg,
	input  rast_pkg::cmd_t    cmd,
	output rast_pkg::status_t sts
);
	import rast_pkg::*;

	len_t                    len_q;
	pos_t                    top;
	pos_t                    hi_clip;
	logic                    op_q;
	pos_t                    lo_q;
	pos_t                    hi_q;
	logic                    empty_q;
	logic signed [VAL_W-1:0] v_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        idx_load;
	logic [IDX_W-1:0]        lowbit;
	len_t                    i0_q;
	len_t                    mult_m;
	logic signed [PROD_W-1:0] prod_v;
	sum_t                    d1_q, d2_q;
	sum_t                    d1_load, d2_load;
	sum_t                    acc1_q, acc2_q, prod_q, res_q, diff;
	logic [ADDR_W-1:0]       addr_q;
	logic [ADDR_W-1:0]       clr_q;
	logic                    we;
	logic [ADDR_W-1:0]       waddr, raddr;
	sum_t                    wdata1, wdata2, rdata1, rdata2;
	logic                    out_valid_q;
	sum_t                    out_data_q;

	assign cfg.ready = 1'b1;
	assign req.ready = cmd.in_ready;

	// Effective last position and range end clipped to it.
	always_comb begin
		if (len_q == '0) top = '0;
		else if (len_q > LEN_W'(NPOS)) top = POS_W'(NPOS - 1);
		else top = POS_W'(len_q - LEN_W'(1));
		hi_clip = (req.range_high > top) ? top : req.range_high;
	end

	// Walk start point and deltas for the current phase.
	always_comb begin
		mult_m = cmd.phase ? (LEN_W'(hi_q) + LEN_W'(1)) : LEN_W'(lo_q);
		prod_v = PROD_W'(v_q) * $signed({1'b0, mult_m});
		d1_load = cmd.phase ? -SUM_W'(v_q) : SUM_W'(v_q);
		d2_load = cmd.phase ? -SUM_W'(prod_v) : SUM_W'(prod_v);
		if (op_q == OP_ADD) begin
			idx_load = cmd.phase ? (IDX_W'(hi_q) + IDX_W'(2)) : (IDX_W'(lo_q) + IDX_W'(1));
		end else begin
			idx_load = cmd.phase ? IDX_W'(lo_q) : (IDX_W'(hi_q) + IDX_W'(1));
		end
		lowbit = idx_q & (~idx_q + IDX_W'(1));
		diff = prod_q - acc2_q;
	end

	// Request capture, walk registers and accumulation.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.op;
			lo_q    <= req.range_low;
			hi_q    <= hi_clip;
			empty_q <= req.range_low > hi_clip;
			v_q     <= req.add_value;
			res_q   <= '0;
		end
		if (cmd.load) begin
			idx_q  <= idx_load;
			i0_q   <= LEN_W'(idx_load);
			d1_q   <= d1_load;
			d2_q   <= d2_load;
			acc1_q <= '0;
			acc2_q <= '0;
		end
		if (cmd.rd) begin
			addr_q <= raddr;
		end
		if (cmd.modify) begin
			if (op_q == OP_ADD) begin
				idx_q <= idx_q + lowbit;
			end else begin
				idx_q  <= idx_q - lowbit;
				acc1_q <= acc1_q + rdata1;
				acc2_q <= acc2_q + rdata2;
			end
		end
		if (cmd.mul) begin
			prod_q <= acc1_q * SUM_W'(i0_q);
		end
		if (cmd.acc) begin
			res_q <= cmd.phase ? (res_q - diff) : (res_q + diff);
		end
	end

	// Length register and clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(NPOS);
			clr_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				len_q <= cfg.length_in_use;
				clr_q <= '0;
			end else if (cmd.clr) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// Store port selection: clearing, then read-modify-write of both stores.
	always_comb begin
		raddr  = ADDR_W'(idx_q - IDX_W'(1));
		we     = cmd.clr || (cmd.modify && (op_q == OP_ADD));
		waddr  = cmd.clr ? clr_q : addr_q;
		wdata1 = cmd.clr ? '0 : (rdata1 + d1_q);
		wdata2 = cmd.clr ? '0 : (rdata2 + d2_q);
	end

	rast_ram #(.WIDTH(SUM_W), .DEPTH(NPOS)) u_ram_b1 (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata1),
		.raddr (raddr),
		.rdata (rdata1)
	);

	rast_ram #(.WIDTH(SUM_W), .DEPTH(NPOS)) u_ram_b2 (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata2),
		.raddr (raddr),
		.rdata (rdata2)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) out_data_q <= res_q;
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.range_sum = out_data_q;

	// Status toward the controller.
	always_comb begin
		sts.in_fire   = req.valid && req.ready;
		sts.cfg_fire  = cfg.valid && cfg.ready;
		sts.op_query  = (op_q == OP_QUERY);
		sts.empty     = empty_q;
		sts.walk_done = (idx_q == '0) || (idx_q > IDX_W'(NPOS));
		sts.clr_last  = (clr_q == ADDR_W'(NPOS - 1));
		sts.out_free  = !out_valid_q || rsp.ready;
	end

endmodule

/* rtl/core/range_add_range_sum_tree_core.sv */
// Top level of the range add / range sum core.
// Usage: an array of 1024 signed 64-bit values, all zero after reset.
// The req channel takes one request at a time: op 0 adds add_value to every
// position from range_low to range_high, op 1 asks for the sum over that range.
// Positions at or above length_in_use take no part (a zero length acts as one);
// an empty range adds nothing and sums to zero. Each query gives one rsp item.
// The cfg channel writes length_in_use (always ready) and clears the array.
// The array is held as two Fenwick trees in two 1024-entry RAMs. An add walks
// up to two index chains of 11 nodes, with a read and a write of both RAMs per
// node. A query walks two chains downward, then multiplies each prefix sum.
// Requests are taken only while the block is idle. After reset, and after each
// length write, a clearing sweep of all 1024 RAM entries runs before the first
// request is taken.
// A finished query sits in an output register; if the receiver stalls, the
// next request is still taken and processed, and only its result delivery waits.
module range_add_range_sum_tree_core (
	input  logic       clk,
	input  logic       arst_n,
	rast_req_if.sink   req,
	rast_rsp_if.source rsp,
	rast_cfg_if.sink   cfg
);
	import rast_pkg::*;

	cmd_t    cmd;
	status_t sts;

	rast_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	rast_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

/* bench/range_add_range_sum_tree_core_tb.sv */
// Self-checking testbench for the range add / range sum core.
`timescale 1ns / 100ps

module range_add_range_sum_tree_core_tb;
	import rast_pkg::*;

	// One pending request for the driver.
	typedef struct {
		logic              op;
		pos_t              lo;
		pos_t              hi;
		logic signed [31:0] val;
	} range_req_t;

	logic clk;
	logic arst_n;

	rast_req_if req_ch ();
	rast_rsp_if rsp_ch ();
	rast_cfg_if cfg_ch ();

	range_add_range_sum_tree_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// Plain array model of the positions, with the effective length.
	logic [63:0] array_val [NPOS];
	int          span;

	range_req_t  pending_reqs [$];
	sum_t        sums_due [$];
	int          errors;
	int          req_idle_pct;
	int          rsp_idle_pct;

	// Apply a length write: clamp and clear the array.
	task automatic apply_length(input len_t len);
		span = (len == 0) ? 1 : ((len > NPOS) ? NPOS : int'(len));
		for (int i = 0; i < NPOS; i++) begin
			array_val[i] = '0;
		end
	endtask

	// Work out the effect of one accepted request.
	task automatic predict_range(input range_req_t r);
		logic [63:0] acc;
		logic [63:0] v64;
		acc = '0;
		v64 = {{32{r.val[31]}}, r.val};
		for (int i = int'(r.lo); i <= int'(r.hi) && i < span; i++) begin
			if (r.op == OP_ADD) begin
				array_val[i] = array_val[i] + v64;
			end else begin
				acc = acc + array_val[i];
			end
		end
		if (r.op == OP_QUERY) begin
			sums_due = {sums_due, acc};
		end
	endtask

	task automatic queue_req(input logic op, input int lo, input int hi,
			input logic [31:0] val);
		range_req_t r;
		r.op = op;
		r.lo = pos_t'(lo);
		r.hi = pos_t'(hi);
		r.val = val;
		pending_reqs = {pending_reqs, r};
	endtask

	// Random request: mostly short ranges, sometimes reversed or wide.
	task automatic queue_random;
		int lo;
		int hi;
		int pick;
		logic [31:0] val;
		pick = $urandom_range(0, 9);
		lo = $urandom_range(0, NPOS - 1);
		if (pick < 6) begin
			hi = lo + $urandom_range(0, 40);
			if (hi > NPOS - 1) hi = NPOS - 1;
		end else if (pick < 8) begin
			hi = $urandom_range(0, NPOS - 1);
		end else begin
			hi = $urandom_range(lo, NPOS - 1);
		end
		case ($urandom_range(0, 3))
			0: val = $urandom_range(0, 15);
			1: val = -$urandom_range(0, 15);
			default: val = $urandom;
		endcase
		queue_req(1'($urandom_range(0, 1)), lo, hi, val);
	endtask

	// Wait until all requests are taken and all sums have arrived.
	task automatic drain;
		while (pending_reqs.size() != 0 || req_ch.valid || sums_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);
	endtask

	// Write the length register while the block is idle.
	task automatic write_length(input len_t len);
		drain();
		cfg_ch.length_in_use <= len;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Directed and random requests for one length setting.
	task automatic run_phase(input len_t len, input int count);
		write_length(len);
		queue_req(OP_QUERY, 0, NPOS - 1, 0);
		queue_req(OP_ADD, 0, NPOS - 1, 32'h7fffffff);
		queue_req(OP_ADD, 0, NPOS - 1, 32'h80000000);
		queue_req(OP_ADD, NPOS - 1, NPOS - 1, 32'hffffffff);
		queue_req(OP_ADD, 5, 3, 32'h12345678);
		queue_req(OP_QUERY, 0, NPOS - 1, 0);
		queue_req(OP_QUERY, 7, 2, 0);
		queue_req(OP_QUERY, 0, 0, 32'hffffffff);
		queue_req(OP_QUERY, NPOS - 1, NPOS - 1, 0);
		queue_req(OP_ADD, 1, 2, 32'h55555555);
		queue_req(OP_QUERY, 0, 3, 32'haaaaaaaa);
		queue_req(OP_QUERY, 512, 1023, 0);
		for (int i = 0; i < count; i++) begin
			queue_random();
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Limit on the whole run.
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) begin
				predict_range('{req_ch.op, req_ch.range_low, req_ch.range_high,
					req_ch.add_value});
			end
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
				range_req_t r;
				r = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.op <= r.op;
				req_ch.range_low <= r.lo;
				req_ch.range_high <= r.hi;
				req_ch.add_value <= r.val;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (sums_due.size() == 0) begin
					$display("%0t: unexpected range_sum %h", $time, rsp_ch.range_sum);
					errors++;
				end else begin
					sum_t want;
					want = sums_due.pop_front();
					if (rsp_ch.range_sum !== want) begin
						$display("%0t: range_sum expected %h actual %h", $time, want,
							rsp_ch.range_sum);
						errors++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
		end
	end

	// Stimulus.
	initial begin
		errors = 0;
		req_idle_pct = 32;
		rsp_idle_pct = 32;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ADD;
		req_ch.range_low = '0;
		req_ch.range_high = '0;
		req_ch.add_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.length_in_use = '0;
		apply_length(len_t'(NPOS));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset length first, without a write.
		queue_req(OP_QUERY, 0, NPOS - 1, 0);
		queue_req(OP_ADD, 0, NPOS - 1, 32'd3);
		queue_req(OP_QUERY, 100, 200, 0);
		for (int i = 0; i < 150; i++) queue_random();
		drain();

		// Length writes model their clear at the accepting edge.
		run_phase(len_t'(1), 60);
		apply_length(len_t'(1));
		run_phase(len_t'(0), 60);
		run_phase(len_t'(2047), 100);
		run_phase(len_t'(1024), 150);
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		run_phase(len_t'(37), 100);
		req_idle_pct = 32;
		rsp_idle_pct = 32;
		run_phase(len_t'(1023), 100);
		run_phase(len_t'(512), 60);
		drain();

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Track length writes at the edge where they are accepted.
	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			apply_length(cfg_ch.length_in_use);
		end
	end

endmodule
